// ===== rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Types, widths and codes shared by the step/direction pulse generator.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Widths of the step counter and of the period and tick counters.
  localparam int STEP_COUNT_BITS = 24;
  localparam int PERIOD_BITS     = 16;
  // Width of the homing limit register.
  localparam int LIMIT_BITS      = 24;
  // Smallest half-period in ticks.
  localparam int MIN_HALF        = 2;

  typedef logic [STEP_COUNT_BITS-1:0] step_cnt_t;
  typedef logic [PERIOD_BITS-1:0]     period_t;
  typedef logic [LIMIT_BITS-1:0]      limit_t;

  // Command codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_MOVE       = 2'd1,
    OP_HOME       = 2'd2,
    OP_SET_ENABLE = 2'd3
  } op_t;

  // Run mode, one-hot.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_MOVE = 3'b010,
    MODE_HOME = 3'b100
  } mode_t;

  // One command word.
  typedef struct packed {
    op_t       operation;
    logic      direction_up;
    step_cnt_t step_count;
    period_t   period_ticks;
    logic      enable_on;
    logic      endstop_level;
  } item_t;

  // One result word.
  typedef struct packed {
    logic step_pin;
    logic dir_pin;
    logic enable_pin_n;
    logic busy_res;
    logic done_res;
  } result_t;

  // Run state kept between words.
  typedef struct packed {
    mode_t     mode;
    logic      step_level;
    logic      dir_level;
    logic      enable_level_n;
    step_cnt_t steps_left;
    period_t   half_period;
    period_t   tick_count;
  } run_state_t;

  // Half-period from a full period, never below the minimum.
  function automatic period_t half_of(period_t period);
    period_t h;
    h = period >> 1;
    if (h < period_t'(MIN_HALF)) begin
      h = period_t'(MIN_HALF);
    end
    return h;
  endfunction

endpackage

// ===== rtl/ssp_ifs.sv =====
// ----------------------------------------------------------------------------
// ssp channel interfaces
// Valid/ready channels for commands, results and the limit register write.
// ----------------------------------------------------------------------------
interface ssp_in_if;
  import ssp_pkg::*;
  logic      valid;
  logic      ready;
  logic [1:0] operation;
  logic      direction_up;
  step_cnt_t step_count;
  period_t   period_ticks;
  logic      enable_on;
  logic      endstop_level;

  modport source (output valid, operation, direction_up, step_count, period_ticks,
                  enable_on, endstop_level, input ready);
  modport sink   (input valid, operation, direction_up, step_count, period_ticks,
                  enable_on, endstop_level, output ready);
endinterface

interface ssp_out_if;
  logic valid;
  logic ready;
  logic step_pin;
  logic dir_pin;
  logic enable_pin_n;
  logic busy_res;
  logic done_res;

  modport source (output valid, step_pin, dir_pin, enable_pin_n, busy_res, done_res,
                  input ready);
  modport sink   (input valid, step_pin, dir_pin, enable_pin_n, busy_res, done_res,
                  output ready);
endinterface

interface ssp_cfg_if;
  import ssp_pkg::*;
  logic   valid;
  logic   ready;
  limit_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/ssp_step_logic.sv =====
// ----------------------------------------------------------------------------
// ssp_step_logic
// Next run state and result for one command word, given the current state.
// ----------------------------------------------------------------------------
module ssp_step_logic
  import ssp_pkg::*;
(
  input  item_t      item,
  input  run_state_t st,
  input  limit_t     home_limit,
  output run_state_t st_nxt,
  output result_t    res
);

  step_cnt_t lim;
  period_t   tick_inc;
  step_cnt_t steps_dec;
  logic      half_done;
  logic      done;

  assign lim       = step_cnt_t'(home_limit);
  assign tick_inc  = st.tick_count + period_t'(1);
  assign steps_dec = st.steps_left - step_cnt_t'(1);
  assign half_done = (tick_inc >= st.half_period);

  // State update for each command.
  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    case (item.operation)
      OP_SET_ENABLE: begin
        st_nxt.enable_level_n = ~item.enable_on;
      end
      OP_MOVE: begin
        if (st.mode == MODE_IDLE && item.step_count != '0) begin
          st_nxt.dir_level      = item.direction_up;
          st_nxt.enable_level_n = 1'b0;
          st_nxt.half_period    = half_of(item.period_ticks);
          st_nxt.steps_left     = item.step_count;
          st_nxt.step_level     = 1'b0;
          st_nxt.tick_count     = '0;
          st_nxt.mode           = MODE_MOVE;
        end
      end
      OP_HOME: begin
        if (st.mode == MODE_IDLE) begin
          st_nxt.dir_level      = 1'b0;
          st_nxt.enable_level_n = 1'b0;
          st_nxt.half_period    = half_of(item.period_ticks);
          st_nxt.tick_count     = '0;
          // Endstop already reached or no allowance: finish at once.
          if (item.endstop_level || lim == '0) begin
            st_nxt.steps_left = '0;
            st_nxt.step_level = 1'b0;
            done              = 1'b1;
          end else begin
            st_nxt.steps_left = lim;
            st_nxt.step_level = 1'b1;
            st_nxt.mode       = MODE_HOME;
          end
        end
      end
      default: begin
        // A tick advances the half-period timer of a running move or home.
        unique case (st.mode)
          MODE_IDLE: begin
          end
          MODE_MOVE: begin
            if (half_done) begin
              st_nxt.tick_count = '0;
              st_nxt.step_level = ~st.step_level;
              // A falling edge completes one step.
              if (st.step_level) begin
                st_nxt.steps_left = steps_dec;
                if (steps_dec == '0) begin
                  st_nxt.mode = MODE_IDLE;
                  done        = 1'b1;
                end
              end
            end else begin
              st_nxt.tick_count = tick_inc;
            end
          end
          MODE_HOME: begin
            if (half_done) begin
              st_nxt.tick_count = '0;
              if (st.step_level) begin
                st_nxt.step_level = 1'b0;
              end else begin
                // End of the low half: count the step and check the endstop.
                st_nxt.steps_left = steps_dec;
                if (steps_dec == '0 || item.endstop_level) begin
                  st_nxt.mode = MODE_IDLE;
                  done        = 1'b1;
                end else begin
                  st_nxt.step_level = 1'b1;
                end
              end
            end else begin
              st_nxt.tick_count = tick_inc;
            end
          end
          default: begin
            st_nxt.mode = MODE_IDLE;
          end
        endcase
      end
    endcase
  end

  // Pin levels after the update.
  assign res.step_pin     = st_nxt.step_level;
  assign res.dir_pin      = st_nxt.dir_level;
  assign res.enable_pin_n = st_nxt.enable_level_n;
  assign res.busy_res     = (st_nxt.mode != MODE_IDLE);
  assign res.done_res     = done;

endmodule

// ===== rtl/stepper_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator
// Step/direction pulse generator with homing, advanced by 1 us tick words.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                        Accepted when
//  in_ch    in   operation, direction_up, step_count,           valid && ready
//                period_ticks, enable_on, endstop_level
//  out_ch   out  step_pin, dir_pin, enable_pin_n, busy_res,     valid && ready
//                done_res
//  cfg_ch   in   data (home_step_limit)                         valid && ready
//
//  One word is taken every cycle; its result appears in the output register
//  on the next cycle. The run state updates in the same cycle as acceptance.
//  While the result register is full and not taken, in_ch.ready is low.
//  Synchronous active-low reset: driver disabled, idle, limit all ones.
//  cfg_ch is always ready.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ssp_in_if.sink     in_ch,
  ssp_out_if.source  out_ch,
  ssp_cfg_if.sink    cfg_ch
);

  run_state_t st_r, st_nxt;
  limit_t     limit_r;
  result_t    result_r, result_nxt;
  logic       out_valid_r;
  item_t      item;
  logic       in_fire;

  // Pack the command word.
  assign item.operation     = op_t'(in_ch.operation);
  assign item.direction_up  = in_ch.direction_up;
  assign item.step_count    = in_ch.step_count;
  assign item.period_ticks  = in_ch.period_ticks;
  assign item.enable_on     = in_ch.enable_on;
  assign item.endstop_level = in_ch.endstop_level;

  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  ssp_step_logic u_logic (
    .item       (item),
    .st         (st_r),
    .home_limit (limit_r),
    .st_nxt     (st_nxt),
    .res        (result_nxt)
  );

  // Run state, limit register and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode           <= MODE_IDLE;
      st_r.step_level     <= 1'b0;
      st_r.dir_level      <= 1'b0;
      st_r.enable_level_n <= 1'b1;
      st_r.steps_left     <= '0;
      st_r.half_period    <= period_t'(MIN_HALF);
      st_r.tick_count     <= '0;
      limit_r             <= '1;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.data;
      end
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.step_pin     = result_r.step_pin;
  assign out_ch.dir_pin      = result_r.dir_pin;
  assign out_ch.enable_pin_n = result_r.enable_pin_n;
  assign out_ch.busy_res     = result_r.busy_res;
  assign out_ch.done_res     = result_r.done_res;

endmodule

// ===== rtl/ssp_checker.sv =====
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module ssp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic step_pin,
  input logic dir_pin,
  input logic enable_pin_n,
  input logic busy_res,
  input logic done_res
);

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A run that ended is no longer busy.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while busy");

  // The step pin is only high during a run.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && step_pin |-> busy_res)
    else $error("step pin high while idle");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(step_pin) && $stable(dir_pin)
      && $stable(enable_pin_n) && $stable(busy_res) && $stable(done_res))
    else $error("stalled result changed");

  // An empty result register never blocks input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind stepper_step_pulse_generator ssp_checker u_ssp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .step_pin     (out_ch.step_pin),
  .dir_pin      (out_ch.dir_pin),
  .enable_pin_n (out_ch.enable_pin_n),
  .busy_res     (out_ch.busy_res),
  .done_res     (out_ch.done_res)
);
